### hdl/tdac_pkg.sv
// shared types and constants for the touch debounce, average and calibrate block
package tdac_pkg;

  localparam int ADC_BITS = 10;
  localparam int CNT_W    = 4;
  localparam int SUM_W    = 14;
  localparam int POS_W    = 9;
  localparam int CFG_IDX_W = 3;

  localparam int STABLE_SAMPLES_DEF = 10;
  localparam int SCREEN_WIDTH_DEF   = 480;
  localparam int SCREEN_HEIGHT_DEF  = 320;

  localparam logic [ADC_BITS-1:0] THRESHOLD_RST = ADC_BITS'(160);
  localparam logic [ADC_BITS-1:0] H_MIN_RST     = ADC_BITS'(187);
  localparam logic [ADC_BITS-1:0] H_MAX_RST     = ADC_BITS'(885);
  localparam logic [ADC_BITS-1:0] V_MIN_RST     = ADC_BITS'(172);
  localparam logic [ADC_BITS-1:0] V_MAX_RST     = ADC_BITS'(935);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_H_MIN     = 3'd1,
    REG_H_MAX     = 3'd2,
    REG_V_MIN     = 3'd3,
    REG_V_MAX     = 3'd4,
    REG_SWAP      = 3'd5,
    REG_INV_H     = 3'd6,
    REG_INV_V     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [ADC_BITS-1:0] threshold;
    logic [ADC_BITS-1:0] h_min;
    logic [ADC_BITS-1:0] h_max;
    logic [ADC_BITS-1:0] v_min;
    logic [ADC_BITS-1:0] v_max;
    logic                swap;
    logic                inv_h;
    logic                inv_v;
  } cfg_t;

  // one completed debounce window
  typedef struct packed {
    logic                pressed;
    logic [SUM_W-1:0]    sum_x;
    logic [SUM_W-1:0]    sum_y;
    logic [ADC_BITS-1:0] pressure;
  } window_t;

  typedef struct packed {
    logic                touched;
    logic [POS_W-1:0]    pos_h;
    logic [POS_W-1:0]    pos_v;
    logic [ADC_BITS-1:0] pressure;
  } res_t;

endpackage

### hdl/tdac_divider.sv
// iterative restoring unsigned divider, one quotient bit per cycle
module tdac_divider #(
  parameter int AW = 23,
  parameter int BW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic          done_o,
  output logic [AW-1:0] quo_o
);

  localparam int CntW = $clog2(AW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [AW-1:0]   quo_q, quo_d;
  logic [BW-1:0]   rem_q, rem_d;
  logic [BW-1:0]   b_q;
  logic [BW:0]     trial;
  logic [BW:0]     sub;
  logic            ge;

  always_comb begin
    trial = {rem_q, quo_q[AW-1]};
    ge    = trial >= {1'b0, b_q};
    sub   = trial - {1'b0, b_q};
    rem_d = ge ? sub[BW-1:0] : trial[BW-1:0];
    quo_d = {quo_q[AW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(AW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q <= a_i;
      rem_q <= '0;
      b_q   <= b_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### hdl/tdac_debounce.sv
// press debounce window with running sums of the raw coordinates
module tdac_debounce #(
  parameter int STABLE_SAMPLES = tdac_pkg::STABLE_SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [tdac_pkg::ADC_BITS-1:0] raw_x_i,
  input  logic [tdac_pkg::ADC_BITS-1:0] raw_y_i,
  input  logic [tdac_pkg::ADC_BITS-1:0] pressure_i,
  input  logic [tdac_pkg::ADC_BITS-1:0] threshold_i,
  output logic                          win_valid_o,
  output tdac_pkg::window_t             win_o
);

  localparam logic [tdac_pkg::CNT_W-1:0] StableC = tdac_pkg::CNT_W'(STABLE_SAMPLES);

  logic                          last_q;
  logic [tdac_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [tdac_pkg::SUM_W-1:0]    sum_x_q, sum_x_d;
  logic [tdac_pkg::SUM_W-1:0]    sum_y_q, sum_y_d;
  logic                          win_valid_q;
  tdac_pkg::window_t             win_q;
  logic                          pressed;

  always_comb begin
    pressed = pressure_i > threshold_i;
    cnt_d   = cnt_q + 1'b1;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    if (pressed) begin
      sum_x_d = sum_x_q + tdac_pkg::SUM_W'(raw_x_i);
      sum_y_d = sum_y_q + tdac_pkg::SUM_W'(raw_y_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= 1'b0;
      cnt_q       <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      win_valid_q <= 1'b0;
    end else begin
      win_valid_q <= 1'b0;
      if (accept_i) begin
        if (pressed != last_q) begin
          // state change restarts the window
          last_q  <= pressed;
          cnt_q   <= '0;
          sum_x_q <= '0;
          sum_y_q <= '0;
        end else if (cnt_d >= StableC) begin
          win_valid_q <= 1'b1;
          last_q      <= 1'b0;
          cnt_q       <= '0;
          sum_x_q     <= '0;
          sum_y_q     <= '0;
        end else begin
          cnt_q   <= cnt_d;
          sum_x_q <= sum_x_d;
          sum_y_q <= sum_y_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q.pressed  <= pressed;
      win_q.sum_x    <= sum_x_d;
      win_q.sum_y    <= sum_y_d;
      win_q.pressure <= pressure_i;
    end
  end

  assign win_valid_o = win_valid_q;
  assign win_o       = win_q;

endmodule

### hdl/tdac_scaler.sv
// sequencer for averaging and linear calibration around the shared divider
module tdac_scaler #(
  parameter int STABLE_SAMPLES = tdac_pkg::STABLE_SAMPLES_DEF,
  parameter int SCREEN_WIDTH   = tdac_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = tdac_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tdac_pkg::cfg_t    cfg_i,
  input  logic              win_valid_i,
  input  tdac_pkg::window_t win_i,
  output logic              idle_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output tdac_pkg::res_t    res_o
);

  localparam int AdcW   = tdac_pkg::ADC_BITS;
  localparam int ScaleMax = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int ScaleW = $clog2(ScaleMax + 1);
  localparam int ProdW  = AdcW + ScaleW;
  localparam int DivAW  = ProdW;
  localparam int DivBW  = AdcW;
  localparam logic [ScaleW-1:0] WidthC  = ScaleW'(SCREEN_WIDTH);
  localparam logic [ScaleW-1:0] HeightC = ScaleW'(SCREEN_HEIGHT);
  // floor of sum over window length as a multiply by a rounded-up reciprocal,
  // exact because the rounding error times any sum stays below 2^RecipS
  localparam int RecipS = tdac_pkg::SUM_W + tdac_pkg::CNT_W;
  localparam int RecipW = RecipS + 1;
  localparam int RecipM = ((1 << RecipS) + STABLE_SAMPLES - 1) / STABLE_SAMPLES;
  localparam int AvgPW  = tdac_pkg::SUM_W + RecipW;
  localparam logic [RecipW-1:0] RecipC = RecipW'(RecipM);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_AVGX = 8'b0000_0010,
    S_AVGY = 8'b0000_0100,
    S_MULH = 8'b0000_1000,
    S_DIVH = 8'b0001_0000,
    S_MULV = 8'b0010_0000,
    S_DIVV = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e                    state_q, state_d;
  logic                      div_go_q;
  logic [DivAW-1:0]          div_a_q;
  logic [DivBW-1:0]          div_b_q;
  logic                      div_done;
  logic [DivAW-1:0]          div_quo;
  logic [tdac_pkg::SUM_W-1:0] sum_x_q;
  logic [tdac_pkg::SUM_W-1:0] sum_y_q;
  logic [AdcW-1:0]           ax_q, ay_q;
  logic [AdcW-1:0]           pressure_q;
  logic                      neg_q, zspan_q;
  logic [ScaleW-1:0]         scale_q;
  logic [tdac_pkg::POS_W-1:0] h_q;
  tdac_pkg::res_t            res_q;

  // averaging step operands
  logic [tdac_pkg::SUM_W-1:0] avg_sum;
  logic [AvgPW-1:0]          avg_prod;
  logic [AdcW-1:0]           avg_quo;

  // multiply step operands
  logic                      horiz;
  logic [AdcW-1:0]           avg, lo, hi;
  logic [ScaleW-1:0]         scale;
  logic [AdcW:0]             diff, span;
  logic [AdcW-1:0]           diff_mag, span_mag;
  logic [ProdW-1:0]          prod;

  // clamp and mirror after division
  logic [ScaleW-1:0]         scale_m1;
  logic [ScaleW-1:0]         scaled;
  logic [ScaleW:0]           h_mir, v_mir;
  logic [ScaleW-1:0]         h_fin, v_fin;

  tdac_divider #(
    .AW(DivAW),
    .BW(DivBW)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .go_i  (div_go_q),
    .a_i   (div_a_q),
    .b_i   (div_b_q),
    .done_o(div_done),
    .quo_o (div_quo)
  );

  always_comb begin
    avg_sum  = (state_q == S_AVGX) ? sum_x_q : sum_y_q;
    avg_prod = AvgPW'(avg_sum) * AvgPW'(RecipC);
    avg_quo  = avg_prod[RecipS +: AdcW];
  end

  always_comb begin
    horiz = (state_q == S_MULH);
    if (horiz) begin
      avg   = cfg_i.swap ? ay_q : ax_q;
      lo    = cfg_i.h_min;
      hi    = cfg_i.h_max;
      scale = cfg_i.swap ? WidthC : HeightC;
    end else begin
      avg   = cfg_i.swap ? ax_q : ay_q;
      lo    = cfg_i.v_min;
      hi    = cfg_i.v_max;
      scale = cfg_i.swap ? HeightC : WidthC;
    end
    diff     = {1'b0, avg} - {1'b0, lo};
    span     = {1'b0, hi} - {1'b0, lo};
    diff_mag = diff[AdcW] ? AdcW'(-diff) : diff[AdcW-1:0];
    span_mag = span[AdcW] ? AdcW'(-span) : span[AdcW-1:0];
    prod     = ProdW'(diff_mag) * ProdW'(scale);
  end

  always_comb begin
    scale_m1 = scale_q - 1'b1;
    if (zspan_q || neg_q) begin
      scaled = '0;
    end else if (div_quo > DivAW'(scale_m1)) begin
      scaled = scale_m1;
    end else begin
      scaled = div_quo[ScaleW-1:0];
    end
    // mirrored values, negative saturates to zero
    h_mir = {1'b0, WidthC - 1'b1} - {1'b0, scaled};
    v_mir = {1'b0, HeightC - 1'b1} - {1'b0, scaled};
    h_fin = scaled;
    if (cfg_i.inv_h) begin
      h_fin = h_mir[ScaleW] ? '0 : h_mir[ScaleW-1:0];
    end
    v_fin = scaled;
    if (cfg_i.swap && cfg_i.inv_v) begin
      v_fin = v_mir[ScaleW] ? '0 : v_mir[ScaleW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (win_valid_i) begin
          state_d = win_i.pressed ? S_AVGX : S_DONE;
        end
      end
      S_AVGX: state_d = S_AVGY;
      S_AVGY: state_d = S_MULH;
      S_MULH: state_d = S_DIVH;
      S_DIVH: if (div_done) state_d = S_MULV;
      S_MULV: state_d = S_DIVV;
      S_DIVV: if (div_done) state_d = S_DONE;
      S_DONE: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      div_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      div_go_q <= (state_q == S_MULH) || (state_q == S_MULV);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (win_valid_i) begin
          pressure_q <= win_i.pressure;
          sum_x_q    <= win_i.sum_x;
          sum_y_q    <= win_i.sum_y;
          res_q      <= '0;
        end
      end
      S_AVGX: begin
        ax_q <= avg_quo;
      end
      S_AVGY: begin
        ay_q <= avg_quo;
      end
      S_MULH, S_MULV: begin
        div_a_q <= DivAW'(prod);
        div_b_q <= span_mag;
        neg_q   <= diff[AdcW] ^ span[AdcW];
        zspan_q <= (span == '0);
        scale_q <= scale;
      end
      S_DIVH: begin
        if (div_done) begin
          h_q <= tdac_pkg::POS_W'(h_fin);
        end
      end
      S_DIVV: begin
        if (div_done) begin
          res_q.touched  <= 1'b1;
          res_q.pos_h    <= h_q;
          res_q.pos_v    <= tdac_pkg::POS_W'(v_fin);
          res_q.pressure <= pressure_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

### hdl/touch_debounce_average_calibrate.sv
// top level of the touch debounce, average and calibrate block
// Each accepted beat is one raw touch sample. A sample is pressed when its
// pressure is strictly above the threshold register. The block counts
// STABLE_SAMPLES samples in a row that agree with the current press state;
// a disagreeing sample adopts the new state and restarts the window. At the
// end of a released window one beat goes out with touched=0 and zero fields.
// At the end of a pressed window the summed raw x and y are averaged, the
// axes are optionally swapped, each axis is mapped from its raw min/max onto
// the screen size, saturated to 0..size-1 (zero span gives 0) and optionally
// mirrored; the beat carries touched=1 and the last sample's pressure.
// A sample that does not close a window does not hold off the next one. A
// sample that closes a released window goes via the scaler's done state
// into the output register. A pressed window is averaged by a reciprocal
// multiply, one axis after the other, then runs two divisions on one
// shared restoring divider, one quotient bit per cycle and DivAW bits each,
// where DivAW is 10 plus the bit width of the larger screen dimension;
// input ready is low until the scaler is idle. A finished beat waits in
// the output register and does not hold off the next sample. Configuration
// is taken at any time but must only change while the block is idle.
module touch_debounce_average_calibrate #(
  parameter int STABLE_SAMPLES = tdac_pkg::STABLE_SAMPLES_DEF,
  parameter int SCREEN_WIDTH   = tdac_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = tdac_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tdac_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tdac_pkg::ADC_BITS-1:0]  cfg_data_i,
  // sample channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tdac_pkg::ADC_BITS-1:0]  raw_x_i,
  input  logic [tdac_pkg::ADC_BITS-1:0]  raw_y_i,
  input  logic [tdac_pkg::ADC_BITS-1:0]  pressure_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           touched_o,
  output logic [tdac_pkg::POS_W-1:0]     pos_horiz_o,
  output logic [tdac_pkg::POS_W-1:0]     pos_vert_o,
  output logic [tdac_pkg::ADC_BITS-1:0]  pressure_out_o
);

  tdac_pkg::cfg_t    cfg_q;
  logic              in_accept;
  logic              win_valid;
  tdac_pkg::window_t win;
  logic              scaler_idle;
  logic              res_valid;
  logic              res_ready;
  tdac_pkg::res_t    res;
  logic              out_valid_q;
  tdac_pkg::res_t    out_q;

  // register file, writes always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= tdac_pkg::THRESHOLD_RST;
      cfg_q.h_min     <= tdac_pkg::H_MIN_RST;
      cfg_q.h_max     <= tdac_pkg::H_MAX_RST;
      cfg_q.v_min     <= tdac_pkg::V_MIN_RST;
      cfg_q.v_max     <= tdac_pkg::V_MAX_RST;
      cfg_q.swap      <= 1'b1;
      cfg_q.inv_h     <= 1'b0;
      cfg_q.inv_v     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (tdac_pkg::cfg_idx_e'(cfg_index_i))
        tdac_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_data_i;
        tdac_pkg::REG_H_MIN:     cfg_q.h_min     <= cfg_data_i;
        tdac_pkg::REG_H_MAX:     cfg_q.h_max     <= cfg_data_i;
        tdac_pkg::REG_V_MIN:     cfg_q.v_min     <= cfg_data_i;
        tdac_pkg::REG_V_MAX:     cfg_q.v_max     <= cfg_data_i;
        tdac_pkg::REG_SWAP:      cfg_q.swap      <= cfg_data_i[0];
        tdac_pkg::REG_INV_H:     cfg_q.inv_h     <= cfg_data_i[0];
        tdac_pkg::REG_INV_V:     cfg_q.inv_v     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // a closed window is handed to the scaler in the cycle after the sample
  assign in_ready_o = scaler_idle && !win_valid;
  assign in_accept  = in_valid_i && in_ready_o;

  tdac_debounce #(
    .STABLE_SAMPLES(STABLE_SAMPLES)
  ) u_debounce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .raw_x_i    (raw_x_i),
    .raw_y_i    (raw_y_i),
    .pressure_i (pressure_i),
    .threshold_i(cfg_q.threshold),
    .win_valid_o(win_valid),
    .win_o      (win)
  );

  tdac_scaler #(
    .STABLE_SAMPLES(STABLE_SAMPLES),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_scaler (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .win_valid_i(win_valid),
    .win_i      (win),
    .idle_o     (scaler_idle),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register, refilled as the held beat leaves
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign touched_o      = out_q.touched;
  assign pos_horiz_o    = out_q.pos_h;
  assign pos_vert_o     = out_q.pos_v;
  assign pressure_out_o = out_q.pressure;

endmodule

### tb/testbench.sv
// self-checking testbench for the touch debounce, average and calibrate block
`timescale 1ns / 1ps

module testbench;
  import tdac_pkg::*;

  localparam int STABLE        = STABLE_SAMPLES_DEF;
  localparam int WIDTH         = SCREEN_WIDTH_DEF;
  localparam int HEIGHT        = SCREEN_HEIGHT_DEF;
  localparam int ADC_MAX       = (1 << ADC_BITS) - 1;
  // a pressed window keeps the block busy
  localparam int SETTLE_CYCLES = 160;
  localparam int HOLD_CYCLES   = 900;
  localparam int PHASES        = 10;
  localparam int PHASE_SAMPLES = 125;

  // predicts the report beats from accepted samples and checks the beats that come out
  class touch_tracker;
    cfg_t             cfg;
    bit               held_pressed;
    logic [CNT_W-1:0] run_len;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    res_t             reports[$];
    int               errors;

    function new();
      cfg = '{THRESHOLD_RST, H_MIN_RST, H_MAX_RST, V_MIN_RST, V_MAX_RST, 1'b1, 1'b0, 1'b0};
      errors = 0;
      clear_window();
    endfunction

    function void clear_window();
      held_pressed = 1'b0;
      run_len = '0;
      sum_x = '0;
      sum_y = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [ADC_BITS-1:0] d);
      case (idx)
        REG_THRESHOLD: cfg.threshold = d;
        REG_H_MIN:     cfg.h_min = d;
        REG_H_MAX:     cfg.h_max = d;
        REG_V_MIN:     cfg.v_min = d;
        REG_V_MAX:     cfg.v_max = d;
        REG_SWAP:      cfg.swap = d[0];
        REG_INV_H:     cfg.inv_h = d[0];
        REG_INV_V:     cfg.inv_v = d[0];
        default: ;
      endcase
    endfunction

    function int clamp_top(longint val, longint top);
      if (val < 0) return 0;
      if (val > top) return int'(top);
      return int'(val);
    endfunction

    // linear map of one averaged axis, truncating division, saturated to the screen
    function int scale_axis(int avg, logic [ADC_BITS-1:0] lo, logic [ADC_BITS-1:0] hi,
                            int span_out);
      longint span;
      longint quot;
      span = longint'(hi) - longint'(lo);
      if (span == 0) return 0;
      quot = ((longint'(avg) - longint'(lo)) * span_out) / span;
      return clamp_top(quot, span_out - 1);
    endfunction

    function void note_sample(logic [ADC_BITS-1:0] x, logic [ADC_BITS-1:0] y,
                              logic [ADC_BITS-1:0] p);
      bit   pressed;
      int   avg_x;
      int   avg_y;
      int   h;
      int   v;
      res_t r;
      pressed = (p > cfg.threshold);
      // a disagreeing sample restarts the window and is not counted
      if (pressed != held_pressed) begin
        held_pressed = pressed;
        run_len = '0;
        sum_x = '0;
        sum_y = '0;
        return;
      end
      run_len = run_len + 1'b1;
      if (pressed) begin
        sum_x = sum_x + SUM_W'(x);
        sum_y = sum_y + SUM_W'(y);
      end
      if (run_len < STABLE) return;
      r = '0;
      if (pressed) begin
        avg_x = int'(sum_x) / STABLE;
        avg_y = int'(sum_y) / STABLE;
        if (cfg.swap) begin
          h = scale_axis(avg_y, cfg.h_min, cfg.h_max, WIDTH);
          v = scale_axis(avg_x, cfg.v_min, cfg.v_max, HEIGHT);
          if (cfg.inv_v) v = clamp_top(HEIGHT - 1 - v, HEIGHT - 1);
        end else begin
          h = scale_axis(avg_x, cfg.h_min, cfg.h_max, HEIGHT);
          v = scale_axis(avg_y, cfg.v_min, cfg.v_max, WIDTH);
        end
        if (cfg.inv_h) h = clamp_top(WIDTH - 1 - h, WIDTH - 1);
        r.touched = 1'b1;
        r.pos_h = POS_W'(h);
        r.pos_v = POS_W'(v);
        r.pressure = p;
      end
      reports.push_back(r);
      clear_window();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(res_t got);
      res_t want;
      if (reports.size() == 0) begin
        $display("%0t: report beat with none expected, actual %0d/%0d/%0d/%0d", $time,
                 got.touched, got.pos_h, got.pos_v, got.pressure);
        errors++;
        return;
      end
      want = reports.pop_front();
      compare_field("touched", 16'(want.touched), 16'(got.touched));
      compare_field("pos_horiz", 16'(want.pos_h), 16'(got.pos_h));
      compare_field("pos_vert", 16'(want.pos_v), 16'(got.pos_v));
      compare_field("pressure_out", 16'(want.pressure), 16'(got.pressure));
    endfunction

    function int pending();
      return reports.size();
    endfunction
  endclass

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [ADC_BITS-1:0]  cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic [ADC_BITS-1:0]  raw_x_i        = '0;
  logic [ADC_BITS-1:0]  raw_y_i        = '0;
  logic [ADC_BITS-1:0]  pressure_i     = '0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic                 touched_o;
  logic [POS_W-1:0]     pos_horiz_o;
  logic [POS_W-1:0]     pos_vert_o;
  logic [ADC_BITS-1:0]  pressure_out_o;

  // idle odds in percent per cycle for each side
  int send_idle_pct = 31;
  int recv_idle_pct = 83;
  // long receiver hold-off, requested by the stimulus and timed in its own process
  bit hold_req  = 1'b0;
  bit recv_hold = 1'b0;

  touch_tracker tracker = new();

  touch_debounce_average_calibrate dut (.*);

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, or a constant stall during a hold-off
  always @(posedge clk_i) begin
    if (recv_hold) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin : receiver_hold_off
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        recv_hold = 1'b0;
      end
    end
  end

  // every report beat is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_report(res_t'({touched_o, pos_horiz_o, pos_vert_o, pressure_out_o}));
    end
  end

  // one sample beat; valid only drops when the sender decides to idle first
  task automatic send_sample(logic [ADC_BITS-1:0] x, logic [ADC_BITS-1:0] y,
                             logic [ADC_BITS-1:0] p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    raw_x_i <= x;
    raw_y_i <= y;
    pressure_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_sample(x, y, p);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [ADC_BITS-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.set_reg(idx, d);
    @(posedge clk_i);
  endtask

  // sender pauses until all reports are in, then lets the divider run dry
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_config(cfg_t c);
    write_reg(REG_THRESHOLD, c.threshold);
    write_reg(REG_H_MIN, c.h_min);
    write_reg(REG_H_MAX, c.h_max);
    write_reg(REG_V_MIN, c.v_min);
    write_reg(REG_V_MAX, c.v_max);
    // single-bit registers get junk in the upper bits
    write_reg(REG_SWAP, {9'($urandom), c.swap});
    write_reg(REG_INV_H, {9'($urandom), c.inv_h});
    write_reg(REG_INV_V, {9'($urandom), c.inv_v});
  endtask

  function automatic cfg_t phase_config(int k);
    cfg_t c;
    c.threshold = ADC_BITS'($urandom_range(20, 1000));
    if ($urandom_range(0, 3) != 0) begin
      c.h_min = ADC_BITS'($urandom_range(0, 400));
      c.h_max = ADC_BITS'($urandom_range(600, ADC_MAX));
      c.v_min = ADC_BITS'($urandom_range(0, 400));
      c.v_max = ADC_BITS'($urandom_range(600, ADC_MAX));
    end else begin
      c.h_min = ADC_BITS'($urandom);
      c.h_max = ADC_BITS'($urandom);
      c.v_min = ADC_BITS'($urandom);
      c.v_max = ADC_BITS'($urandom);
    end
    c.swap = 1'($urandom);
    c.inv_h = 1'($urandom);
    c.inv_v = 1'($urandom);
    case (k)
      // reset values, written explicitly
      0: c = '{THRESHOLD_RST, H_MIN_RST, H_MAX_RST, V_MIN_RST, V_MAX_RST, 1'b1, 1'b0, 1'b0};
      // any nonzero pressure presses, full raw range, portrait with both mirrors set
      1: c = '{'0, '0, ADC_BITS'(ADC_MAX), '0, ADC_BITS'(ADC_MAX), 1'b0, 1'b1, 1'b1};
      // nothing can ever press
      2: c.threshold = ADC_BITS'(ADC_MAX);
      // zero span on both axes
      3: begin
        c.h_max = c.h_min;
        c.v_max = c.v_min;
        c.swap = 1'b1;
        c.inv_h = 1'b1;
        c.inv_v = 1'b1;
      end
      // reversed bounds
      4: begin
        c.h_min = ADC_BITS'(ADC_MAX);
        c.h_max = '0;
        c.v_min = ADC_BITS'(900);
        c.v_max = ADC_BITS'(100);
        c.swap = 1'b1;
        c.inv_v = 1'b1;
      end
      // span of one count, almost everything saturates
      5: begin
        c.h_min = ADC_BITS'(500);
        c.h_max = ADC_BITS'(501);
        c.v_min = ADC_BITS'(300);
        c.v_max = ADC_BITS'(299);
      end
      default: ;
    endcase
    return c;
  endfunction

  // pressure on the wanted side of the threshold, boundary values now and then
  function automatic logic [ADC_BITS-1:0] pressure_for(bit press);
    int thr;
    thr = int'(tracker.cfg.threshold);
    if (press && thr != ADC_MAX) begin
      if ($urandom_range(0, 9) == 0) return ADC_BITS'(thr + 1);
      return ADC_BITS'($urandom_range(thr + 1, ADC_MAX));
    end
    if ($urandom_range(0, 9) == 0) return ADC_BITS'(thr);
    return ADC_BITS'($urandom_range(0, thr));
  endfunction

  function automatic logic [ADC_BITS-1:0] jitter_adc(int center, int spread);
    int val;
    val = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (val < 0) val = 0;
    if (val > ADC_MAX) val = ADC_MAX;
    return ADC_BITS'(val);
  endfunction

  // mostly full windows around one touch point, some short noisy bursts
  task automatic send_stroke(output int count);
    bit noise;
    bit want_press;
    int len;
    int cx;
    int cy;
    int spread;
    logic [ADC_BITS-1:0] p;
    noise = ($urandom_range(0, 99) < 15);
    want_press = ($urandom_range(0, 99) < 60);
    if (noise) begin
      len = $urandom_range(1, STABLE - 1);
    end else if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(STABLE + 3, 2 * STABLE + 2);
    end else begin
      len = $urandom_range(STABLE, STABLE + 2);
    end
    cx = $urandom_range(0, ADC_MAX);
    cy = $urandom_range(0, ADC_MAX);
    spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
    if (noise) spread = ADC_MAX;
    for (int i = 0; i < len; i++) begin
      p = (noise && $urandom_range(0, 1) == 1) ? ADC_BITS'($urandom) : pressure_for(want_press);
      send_sample(jitter_adc(cx, spread), jitter_adc(cy, spread), p);
    end
    count = len;
  endtask

  initial begin : stimulus
    int sent;
    int n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // released window with pressure sitting exactly on the threshold
    repeat (STABLE) send_sample('0, '0, THRESHOLD_RST);
    // press broken off by a released sample before the window fills
    repeat (3) send_sample(ADC_BITS'(500), ADC_BITS'(500), THRESHOLD_RST + 1'b1);
    send_sample(ADC_BITS'(ADC_MAX), '0, '0);
    // full-scale press, both axes saturate high
    repeat (STABLE + 1) send_sample('1, '1, '1);

    // receiver stalls for a long stretch while the sender keeps pushing pressed windows
    wait_idle();
    hold_req = 1'b1;
    send_idle_pct = 0;
    repeat (3) begin
      repeat (STABLE + 1) begin
        send_sample(ADC_BITS'($urandom), ADC_BITS'($urandom), pressure_for(1'b1));
      end
    end
    send_idle_pct = 31;

    for (int k = 0; k < PHASES; k++) begin
      if (k == 4) begin
        send_idle_pct = 83;
        recv_idle_pct = 31;
      end
      if (k == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_idle();
      program_config(phase_config(k));
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        send_stroke(n);
        sent += n;
      end
    end

    wait_idle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
hdl/tdac_pkg.sv
hdl/tdac_divider.sv
hdl/tdac_debounce.sv
hdl/tdac_scaler.sv
hdl/touch_debounce_average_calibrate.sv
tb/testbench.sv
